// ===== rtl/core/ipr_pkg.sv =====
// Shared types and constants for the inverse perspective pixel remap block.
package ipr_pkg;

  localparam int COEF_W    = 48;
  localparam int COL_W     = 10;
  localparam int ROW_W     = 9;
  localparam int COLOR_W   = 24;
  localparam int NUM_COEF  = 8;
  localparam int FRAC_BITS = 28;

  localparam int IMG_WIDTH  = 640;
  localparam int IMG_HEIGHT = 480;
  localparam int COL_OFFSET = 100;
  localparam int ROW_OFFSET = 400;
  localparam int SCALE      = 2;

  localparam int TERM_W    = 64;
  localparam int HALF_W    = TERM_W / 2;
  localparam int WIDE_W    = 2 * TERM_W;
  localparam int DIV_STEPS = 12;
  localparam int NUM_PROD  = 6;

  localparam int MIDQ_DEPTH = 4;
  localparam int MIDQ_AW    = $clog2(MIDQ_DEPTH);
  localparam int OUTQ_DEPTH = 2;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic [WIDE_W-1:0]        wide_t;
  typedef logic [DIV_STEPS-1:0]     quot_t;

  typedef enum logic [2:0] {
    CFG_M0, CFG_M1, CFG_M2, CFG_M3, CFG_M4, CFG_M5, CFG_M6, CFG_M7
  } cfg_idx_t;

  localparam coef_t COEF_RESET [NUM_COEF] = '{
    48'sd268435456, 48'sd0, 48'sd0, 48'sd0, 48'sd268435456, 48'sd0, 48'sd0, 48'sd0
  };

  // Reduced terms of the 2x2 system, as left by the front part.
  typedef struct packed {
    term_t              a;
    term_t              b;
    term_t              c;
    term_t              d;
    term_t              e;
    term_t              f;
    logic [COLOR_W-1:0] color;
  } front_item_t;

  typedef struct packed {
    wide_t              an_c;
    wide_t              an_r;
    wide_t              ad;
    quot_t              q_c;
    quot_t              q_r;
    logic               ok;
    logic [COLOR_W-1:0] color;
  } div_item_t;

  typedef struct packed {
    logic [COL_W-1:0]   dst_col;
    logic [ROW_W-1:0]   dst_row;
    logic               write_ok;
    logic [COLOR_W-1:0] dst_color;
  } result_t;

  // Handshake between the front queue and the back pipeline.
  typedef struct packed {
    logic empty;
  } midq_stat_t;

endpackage

// ===== rtl/core/ipr_front.sv =====
// Front part: forms the reduced system terms per pixel and queues them.
module ipr_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ipr_pkg::coef_t              coef [ipr_pkg::NUM_COEF],
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [ipr_pkg::COL_W-1:0]   in_src_col,
  input  logic [ipr_pkg::ROW_W-1:0]   in_src_row,
  input  logic [ipr_pkg::COLOR_W-1:0] in_src_color,
  input  logic                        mid_pop,
  output ipr_pkg::midq_stat_t         mid_stat,
  output ipr_pkg::front_item_t        mid_item
);
  import ipr_pkg::*;

  logic signed [COL_W:0]    u_s;
  logic signed [ROW_W:0]    v_s;
  logic signed [TERM_W-1:0] m7v, m7u, m6v, m6u, u_one, v_one;
  front_item_t              item;

  front_item_t              mem [MIDQ_DEPTH];
  logic [MIDQ_AW-1:0]       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [MIDQ_AW:0]         cnt_r, cnt_nxt;
  logic                     push, pop;

  always_comb begin
    u_s   = $signed({1'b0, in_src_col});
    v_s   = $signed({1'b0, in_src_row});
    m7v   = TERM_W'(coef[CFG_M7]) * TERM_W'(v_s);
    m7u   = TERM_W'(coef[CFG_M7]) * TERM_W'(u_s);
    m6v   = TERM_W'(coef[CFG_M6]) * TERM_W'(v_s);
    m6u   = TERM_W'(coef[CFG_M6]) * TERM_W'(u_s);
    u_one = TERM_W'(u_s) <<< FRAC_BITS;
    v_one = TERM_W'(v_s) <<< FRAC_BITS;
    item.a     = TERM_W'(coef[CFG_M4]) - m7v;
    item.b     = TERM_W'(coef[CFG_M1]) - m7u;
    item.c     = TERM_W'(coef[CFG_M3]) - m6v;
    item.d     = TERM_W'(coef[CFG_M0]) - m6u;
    item.e     = TERM_W'(coef[CFG_M2]) - u_one;
    item.f     = TERM_W'(coef[CFG_M5]) - v_one;
    item.color = in_src_color;
  end

  assign in_full        = (cnt_r == (MIDQ_AW+1)'(MIDQ_DEPTH));
  assign mid_stat.empty = (cnt_r == '0);
  assign push           = in_push && !in_full;
  assign pop            = mid_pop && !mid_stat.empty;
  assign mid_item       = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (MIDQ_AW+1)'(push) - (MIDQ_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= item;
    end
  end

endmodule

// ===== rtl/core/ipr_back.sv =====
// Back part: Cramer products, target numerators, range checks, division and result queue.
module ipr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ipr_pkg::midq_stat_t  mid_stat,
  input  ipr_pkg::front_item_t mid_item,
  output logic                 mid_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output ipr_pkg::result_t     out_res
);
  import ipr_pkg::*;

  // Operand pairs of the six products: ae, bf, ad, bc, ce, df.
  localparam int OPA [NUM_PROD] = '{0, 1, 0, 1, 2, 3};
  localparam int OPB [NUM_PROD] = '{4, 5, 3, 2, 4, 5};

  logic en;

  // Stage 1: magnitudes and signs.
  logic                 v1_r;
  logic [TERM_W-1:0]    mag_r [6];
  logic                 sgn_r [6];
  logic [COLOR_W-1:0]   col1_r;
  term_t                terms [6];

  // Stage 2: 32x32 partial products.
  logic                 v2_r;
  logic [TERM_W-1:0]    pp_r [NUM_PROD][4];
  logic                 psg2_r [NUM_PROD];
  logic [COLOR_W-1:0]   col2_r;

  // Stage 3: product magnitudes.
  logic                 v3_r;
  wide_t                pm_r [NUM_PROD];
  logic                 psg3_r [NUM_PROD];
  logic [COLOR_W-1:0]   col3_r;
  logic signed [WIDE_W-1:0] sp [NUM_PROD];

  // Stage 4: determinants.
  logic                 v4_r;
  logic signed [WIDE_W-1:0] nx_r, dx4_r, ny_r;
  logic [COLOR_W-1:0]   col4_r;

  // Stage 5: scaled terms.
  logic                 v5_r;
  logic signed [WIDE_W-1:0] sc_r, oc_r, sr_r, or_r, dx5_r;
  logic [COLOR_W-1:0]   col5_r;

  // Stage 6: numerators.
  logic                 v6_r;
  logic signed [WIDE_W-1:0] ncol_r, nrow_r, dx6_r;
  logic [COLOR_W-1:0]   col6_r;

  // Stage 7: signs and magnitudes.
  logic                 v7_r;
  wide_t                anc7_r, anr7_r, ad7_r;
  logic                 okc7_r, okr7_r;
  logic [COLOR_W-1:0]   col7_r;

  // Stage 8: range limits.
  logic                 v8_r;
  wide_t                anc8_r, anr8_r, ad8_r, limc_r, limr_r;
  logic                 okc8_r, okr8_r;
  logic [COLOR_W-1:0]   col8_r;

  // Division stages.
  logic                 dv_v_r [DIV_STEPS+1];
  div_item_t            dv_r   [DIV_STEPS+1];
  div_item_t            dv0;

  // Result queue.
  result_t              oq_mem [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]   oq_wr_r, oq_rd_r;
  logic [OUTQ_AW:0]     oq_cnt_r;
  logic                 oq_full, oq_push, oq_pop;
  result_t              res;

  // The whole pipeline holds only when its last stage cannot leave.
  assign oq_full = (oq_cnt_r == (OUTQ_AW+1)'(OUTQ_DEPTH));
  assign en      = !(dv_v_r[DIV_STEPS] && oq_full);
  assign mid_pop = en && !mid_stat.empty;

  assign terms[0] = mid_item.a;
  assign terms[1] = mid_item.b;
  assign terms[2] = mid_item.c;
  assign terms[3] = mid_item.d;
  assign terms[4] = mid_item.e;
  assign terms[5] = mid_item.f;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        mag_r[i] <= terms[i][TERM_W-1] ? TERM_W'(-terms[i]) : TERM_W'(terms[i]);
        sgn_r[i] <= terms[i][TERM_W-1];
      end
      col1_r <= mid_item.color;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < NUM_PROD; p++) begin
        pp_r[p][0] <= TERM_W'(mag_r[OPA[p]][HALF_W-1:0] * mag_r[OPB[p]][HALF_W-1:0]);
        pp_r[p][1] <= TERM_W'(mag_r[OPA[p]][HALF_W-1:0] * mag_r[OPB[p]][TERM_W-1:HALF_W]);
        pp_r[p][2] <= TERM_W'(mag_r[OPA[p]][TERM_W-1:HALF_W] * mag_r[OPB[p]][HALF_W-1:0]);
        pp_r[p][3] <= TERM_W'(mag_r[OPA[p]][TERM_W-1:HALF_W] *
                              mag_r[OPB[p]][TERM_W-1:HALF_W]);
        psg2_r[p]  <= sgn_r[OPA[p]] ^ sgn_r[OPB[p]];
      end
      col2_r <= col1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < NUM_PROD; p++) begin
        pm_r[p]   <= WIDE_W'(pp_r[p][0]) + (WIDE_W'(pp_r[p][1]) << HALF_W) +
                     (WIDE_W'(pp_r[p][2]) << HALF_W) + {pp_r[p][3], {TERM_W{1'b0}}};
        psg3_r[p] <= psg2_r[p];
      end
      col3_r <= col2_r;
    end
  end

  always_comb begin
    for (int p = 0; p < NUM_PROD; p++) begin
      sp[p] = psg3_r[p] ? -$signed(pm_r[p]) : $signed(pm_r[p]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r   <= sp[0] - sp[1];
      dx4_r  <= sp[2] - sp[3];
      ny_r   <= sp[4] - sp[5];
      col4_r <= col3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_r   <= nx_r * $signed(WIDE_W'(SCALE));
      oc_r   <= dx4_r * $signed(WIDE_W'(COL_OFFSET));
      sr_r   <= ny_r * $signed(WIDE_W'(SCALE));
      or_r   <= dx4_r * $signed(WIDE_W'(ROW_OFFSET));
      dx5_r  <= dx4_r;
      col5_r <= col4_r;
    end
  end

  // The row denominator is the negated column one, so the row offset enters negated.
  always_ff @(posedge clk) begin
    if (en) begin
      ncol_r <= -sc_r - oc_r;
      nrow_r <= -sr_r - or_r;
      dx6_r  <= dx5_r;
      col6_r <= col5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      anc7_r <= ncol_r[WIDE_W-1] ? WIDE_W'(-ncol_r) : WIDE_W'(ncol_r);
      anr7_r <= nrow_r[WIDE_W-1] ? WIDE_W'(-nrow_r) : WIDE_W'(nrow_r);
      ad7_r  <= dx6_r[WIDE_W-1] ? WIDE_W'(-dx6_r) : WIDE_W'(dx6_r);
      okc7_r <= (ncol_r != '0) && (dx6_r != '0) && (ncol_r[WIDE_W-1] == dx6_r[WIDE_W-1]);
      okr7_r <= (nrow_r != '0) && (dx6_r != '0) && (nrow_r[WIDE_W-1] != dx6_r[WIDE_W-1]);
      col7_r <= col6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      anc8_r <= anc7_r;
      anr8_r <= anr7_r;
      ad8_r  <= ad7_r;
      limc_r <= ad7_r * WIDE_W'(IMG_WIDTH);
      limr_r <= ad7_r * WIDE_W'(IMG_HEIGHT);
      okc8_r <= okc7_r;
      okr8_r <= okr7_r;
      col8_r <= col7_r;
    end
  end

  always_comb begin
    dv0.an_c  = anc8_r;
    dv0.an_r  = anr8_r;
    dv0.ad    = ad8_r;
    dv0.q_c   = '0;
    dv0.q_r   = '0;
    dv0.ok    = okc8_r && (anc8_r >= ad8_r) && (anc8_r < limc_r) &&
                okr8_r && (anr8_r >= ad8_r) && (anr8_r < limr_r);
    dv0.color = col8_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= dv0;
    end
  end

  // One restoring quotient bit per stage, most significant first.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int BIT = DIV_STEPS - 1 - k;
    wide_t     t;
    div_item_t nxt;

    always_comb begin
      t   = dv_r[k].ad << BIT;
      nxt = dv_r[k];
      if (dv_r[k].an_c >= t) begin
        nxt.an_c     = dv_r[k].an_c - t;
        nxt.q_c[BIT] = 1'b1;
      end
      if (dv_r[k].an_r >= t) begin
        nxt.an_r     = dv_r[k].an_r - t;
        nxt.q_r[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[k+1] <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) begin
        dv_v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v1_r      <= mid_pop;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      v5_r      <= v4_r;
      v6_r      <= v5_r;
      v7_r      <= v6_r;
      v8_r      <= v7_r;
      dv_v_r[0] <= v8_r;
      for (int k = 0; k < DIV_STEPS; k++) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end
  end

  always_comb begin
    res.write_ok  = dv_r[DIV_STEPS].ok;
    res.dst_col   = dv_r[DIV_STEPS].ok ? dv_r[DIV_STEPS].q_c[COL_W-1:0] : '0;
    res.dst_row   = dv_r[DIV_STEPS].ok ? dv_r[DIV_STEPS].q_r[ROW_W-1:0] : '0;
    res.dst_color = dv_r[DIV_STEPS].color;
  end

  assign oq_push   = dv_v_r[DIV_STEPS] && !oq_full;
  assign out_empty = (oq_cnt_r == '0);
  assign oq_pop    = out_pop && !out_empty;
  assign out_res   = oq_mem[oq_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_r <= oq_wr_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + 1'b1;
      end
      oq_cnt_r <= oq_cnt_r + (OUTQ_AW+1)'(oq_push) - (OUTQ_AW+1)'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_mem[oq_wr_r] <= res;
    end
  end

endmodule

// ===== rtl/core/inverse_perspective_pixel_remap_top.sv =====
// Top level of the inverse perspective pixel remap block: coefficient registers and the two parts.
// Usage:
// Pixels enter on the in_ channel: a transfer happens when in_push is high and in_full low.
// Each pixel gives exactly one top-view write on the out_ channel, in arrival order; the
// oldest result stands on the out_ ports while out_empty is low and leaves on out_pop.
// out_write_ok is set only when the target lies strictly inside the image and the
// system is solvable; otherwise the target coordinates read as zero.
// The user writes the eight coefficients through cfg_index and cfg_wdata only while the block
// is idle; the block itself does not enforce this. cfg_ready is always high and every register
// takes its identity-map value at reset. Throughput is one pixel per clock while the result
// queue can take results. An input transfer is written to the front queue, read into the
// product, numerator and range stages, loaded into the divider, taken through the restoring
// division (one quotient bit per stage) and written to the result queue, where it is visible.
// When the receiver stalls, the back pipeline holds once its last stage cannot enter the
// two-entry result queue; the four-entry front queue then fills and raises in_full.
// Reset empties both queues and clears all pipeline valid flags.
module inverse_perspective_pixel_remap_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [ipr_pkg::COL_W-1:0]   in_src_col,
  input  logic [ipr_pkg::ROW_W-1:0]   in_src_row,
  input  logic [ipr_pkg::COLOR_W-1:0] in_src_color,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [ipr_pkg::COL_W-1:0]   out_dst_col,
  output logic [ipr_pkg::ROW_W-1:0]   out_dst_row,
  output logic                        out_write_ok,
  output logic [ipr_pkg::COLOR_W-1:0] out_dst_color,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  ipr_pkg::cfg_idx_t           cfg_index,
  input  logic [ipr_pkg::COEF_W-1:0]  cfg_wdata
);
  import ipr_pkg::*;

  coef_t       coef_r [NUM_COEF];
  midq_stat_t  mid_stat;
  front_item_t mid_item;
  logic        mid_pop;
  result_t     out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= COEF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      coef_r[cfg_index] <= $signed(cfg_wdata);
    end
  end

  ipr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .coef         (coef_r),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_src_col   (in_src_col),
    .in_src_row   (in_src_row),
    .in_src_color (in_src_color),
    .mid_pop      (mid_pop),
    .mid_stat     (mid_stat),
    .mid_item     (mid_item)
  );

  ipr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_stat  (mid_stat),
    .mid_item  (mid_item),
    .mid_pop   (mid_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (out_res)
  );

  assign out_dst_col   = out_res.dst_col;
  assign out_dst_row   = out_res.dst_row;
  assign out_write_ok  = out_res.write_ok;
  assign out_dst_color = out_res.dst_color;

  // A valid write always targets a strictly positive position.
  a_ok_target: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_write_ok) |-> (out_dst_col != '0) && (out_dst_row != '0))
    else $error("write enabled with a zero target coordinate");

  // A rejected write carries zeroed coordinates.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_write_ok) |-> (out_dst_col == '0) && (out_dst_row == '0))
    else $error("rejected write with nonzero target");

  // Both queues come out of reset empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

endmodule
